>>> rtl/assert_macros.svh
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// a implies b in the same cycle
`define ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// a implies b in the following cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

>>> rtl/ldsg_pkg.sv
`timescale 1ns / 1ps

package ldsg_pkg;

   localparam int LOAD_W    = 16;
   localparam int IDLE_W    = 32;
   localparam int ELAPSED_W = 24;
   localparam int LEVEL_W   = 4;
   localparam int PCT_W     = 7;
   localparam int MS_W      = 16;
   localparam int ACTION_W  = 2;
   localparam int DEC_W     = 15;   // elapsed_us / 1000 stays below 2^15
   localparam int CD_W      = 18;   // signed countdown during a tick
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // floor(x / 1000) = (x * DIV1000_MUL) >> DIV1000_SHIFT for any 24-bit x
   localparam int MUL_W = 25;
   localparam logic [MUL_W-1:0] DIV1000_MUL = 25'd17179870;
   localparam int DIV1000_SHIFT = 34;

   localparam logic [IDLE_W-1:0] US_PER_MS  = 32'd1000;
   localparam logic [LOAD_W-1:0] HUNDREDTHS = 16'd100;

   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_STEP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_OFF  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_USE_RQ    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UP_THR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UP_HOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DN_THR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DN_HOLD   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_OFF  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_LVL   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_LVL  = 3'd7;

   // pre-decoded tick held in the input register
   typedef struct packed {
      logic               busy_nz;
      logic               load_nz;
      logic               idle_over;
      logic               high_load;
      logic               low_load;
      logic [DEC_W-1:0]   dec_ms;
      logic [LEVEL_W-1:0] cur_level;
   } tick_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [LEVEL_W-1:0]  new_level;
      logic                active_flag;
   } result_type;

endpackage

>>> rtl/ldsg_if.sv
`timescale 1ns / 1ps

interface ldsg_req_if;
   logic                              valid;
   logic                              ready;
   logic [ldsg_pkg::LOAD_W-1:0]       load_hundredths;
   logic [ldsg_pkg::LOAD_W-1:0]       runqueue_load;
   logic [ldsg_pkg::IDLE_W-1:0]       idle_time_us;
   logic [ldsg_pkg::ELAPSED_W-1:0]    elapsed_us;
   logic [ldsg_pkg::LEVEL_W-1:0]      current_level;

   modport source (output valid, load_hundredths, runqueue_load, idle_time_us,
                   elapsed_us, current_level, input ready);
   modport sink   (input valid, load_hundredths, runqueue_load, idle_time_us,
                   elapsed_us, current_level, output ready);
endinterface

interface ldsg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ldsg_pkg::ACTION_W-1:0]     action;
   logic [ldsg_pkg::LEVEL_W-1:0]      new_level;
   logic                              active_flag;

   modport source (output valid, action, new_level, active_flag, input ready);
   modport sink   (input valid, action, new_level, active_flag, output ready);
endinterface

interface ldsg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ldsg_pkg::CSR_IDX_W-1:0]    index;
   logic [ldsg_pkg::CSR_DAT_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/load_based_dvfs_step_governor.sv
// An accepted tick waits in the input register until the result register is free.
// One tick per cycle if rsp_ch is ready; input and result registers hold one beat each.
// The elapsed-time divide by 1000 is a reciprocal multiply ahead of the input register.
// Reset: synchronous, active high; registers back to defaults, countdowns and
// running flag cleared, both channels empty. Config writes are taken every cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module load_based_dvfs_step_governor #(
   parameter int LEVEL_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   ldsg_req_if.sink   req_ch,
   ldsg_rsp_if.source rsp_ch,
   ldsg_csr_if.sink   csr_ch
);

   localparam int CMP_W = 7;
   localparam logic [CMP_W-1:0] LEVEL_LIMIT = CMP_W'(LEVEL_COUNT);

   // configuration
   logic                             use_rq_ff;
   logic [ldsg_pkg::PCT_W-1:0]       up_thr_ff;
   logic [ldsg_pkg::MS_W-1:0]        up_hold_ff;
   logic [ldsg_pkg::PCT_W-1:0]       dn_thr_ff;
   logic [ldsg_pkg::MS_W-1:0]        dn_hold_ff;
   logic [ldsg_pkg::MS_W-1:0]        idle_off_ff;
   logic [ldsg_pkg::LEVEL_W-1:0]     low_lvl_ff;
   logic [ldsg_pkg::LEVEL_W-1:0]     high_lvl_ff;

   // state
   logic [ldsg_pkg::MS_W-1:0]        up_cd_ff, up_cd_in;
   logic [ldsg_pkg::MS_W-1:0]        dn_cd_ff, dn_cd_in;
   logic                             run_ff, run_in;

   // pipeline
   logic                             s1_valid_ff;
   ldsg_pkg::tick_type               s1_ff, s1_in;
   logic                             rsp_valid_ff;
   ldsg_pkg::result_type             rsp_ff, rsp_in;

   logic                             req_take;
   logic                             s1_adv;
   logic [ldsg_pkg::LOAD_W-1:0]      busy;
   logic [ldsg_pkg::ELAPSED_W+ldsg_pkg::MUL_W-1:0] dec_prod;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_rq_ff   <= 1'b0;
         up_thr_ff   <= 7'd100;
         up_hold_ff  <= '0;
         dn_thr_ff   <= '0;
         dn_hold_ff  <= '0;
         idle_off_ff <= '0;
         low_lvl_ff  <= '0;
         high_lvl_ff <= 4'd15;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            ldsg_pkg::REG_USE_RQ:   use_rq_ff   <= csr_ch.data[0];
            ldsg_pkg::REG_UP_THR:   up_thr_ff   <= csr_ch.data[ldsg_pkg::PCT_W-1:0];
            ldsg_pkg::REG_UP_HOLD:  up_hold_ff  <= csr_ch.data;
            ldsg_pkg::REG_DN_THR:   dn_thr_ff   <= csr_ch.data[ldsg_pkg::PCT_W-1:0];
            ldsg_pkg::REG_DN_HOLD:  dn_hold_ff  <= csr_ch.data;
            ldsg_pkg::REG_IDLE_OFF: idle_off_ff <= csr_ch.data;
            ldsg_pkg::REG_LOW_LVL:  low_lvl_ff  <= csr_ch.data[ldsg_pkg::LEVEL_W-1:0];
            ldsg_pkg::REG_HIGH_LVL: high_lvl_ff <= csr_ch.data[ldsg_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the input stage moves on when the result register is empty or draining
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;

   // decode the incoming beat
   always_comb begin
      busy     = use_rq_ff ? req_ch.runqueue_load : req_ch.load_hundredths;
      dec_prod = (ldsg_pkg::ELAPSED_W+ldsg_pkg::MUL_W)'(req_ch.elapsed_us)
                 * (ldsg_pkg::ELAPSED_W+ldsg_pkg::MUL_W)'(ldsg_pkg::DIV1000_MUL);
      s1_in.busy_nz   = (busy != '0);
      s1_in.load_nz   = (req_ch.load_hundredths != '0);
      s1_in.idle_over = (idle_off_ff != '0) &&
                        (req_ch.idle_time_us >
                         ldsg_pkg::IDLE_W'(idle_off_ff) * ldsg_pkg::US_PER_MS);
      s1_in.high_load = req_ch.load_hundredths >
                        ldsg_pkg::LOAD_W'(up_thr_ff) * ldsg_pkg::HUNDREDTHS;
      s1_in.low_load  = req_ch.load_hundredths <
                        ldsg_pkg::LOAD_W'(dn_thr_ff) * ldsg_pkg::HUNDREDTHS;
      s1_in.dec_ms    = dec_prod[ldsg_pkg::DIV1000_SHIFT +: ldsg_pkg::DEC_W];
      s1_in.cur_level = req_ch.current_level;
   end

   // countdown update and level decision
   always_comb begin
      logic signed [ldsg_pkg::CD_W-1:0] up_v;
      logic signed [ldsg_pkg::CD_W-1:0] dn_v;
      logic signed [ldsg_pkg::CD_W-1:0] dec_s;
      logic signed [ldsg_pkg::CD_W-1:0] up_hold_s;
      logic signed [ldsg_pkg::CD_W-1:0] dn_hold_s;
      logic [CMP_W-1:0]                 next_idx;

      dec_s     = ldsg_pkg::CD_W'(s1_ff.dec_ms);
      up_hold_s = ldsg_pkg::CD_W'(up_hold_ff);
      dn_hold_s = ldsg_pkg::CD_W'(dn_hold_ff);
      up_v      = ldsg_pkg::CD_W'(up_cd_ff);
      dn_v      = ldsg_pkg::CD_W'(dn_cd_ff);
      next_idx  = CMP_W'(s1_ff.cur_level) + CMP_W'(1);
      run_in    = run_ff;
      rsp_in.action    = ldsg_pkg::ACT_NONE;
      rsp_in.new_level = '0;

      if (s1_ff.busy_nz && !s1_ff.load_nz) begin
         // skipped tick: nothing moves
      end else if (!s1_ff.busy_nz && s1_ff.idle_over) begin
         run_in        = 1'b0;
         rsp_in.action = ldsg_pkg::ACT_OFF;
      end else begin
         run_in = 1'b1;
         if (s1_ff.high_load) begin
            up_v = up_v - dec_s;
            dn_v = dn_hold_s;
            if (up_v[ldsg_pkg::CD_W-1] || up_v == '0) begin
               if (s1_ff.cur_level < high_lvl_ff && next_idx < LEVEL_LIMIT) begin
                  rsp_in.action    = ldsg_pkg::ACT_STEP;
                  rsp_in.new_level = s1_ff.cur_level + 1'b1;
               end
               up_v = up_hold_s;
            end
         end
         // runs after the up test so a step down wins
         if (s1_ff.low_load) begin
            up_v = up_hold_s;
            dn_v = dn_v - dec_s;
            if (dn_v[ldsg_pkg::CD_W-1] || dn_v == '0) begin
               if (s1_ff.cur_level > low_lvl_ff) begin
                  rsp_in.action    = ldsg_pkg::ACT_STEP;
                  rsp_in.new_level = s1_ff.cur_level - 1'b1;
               end
               dn_v = dn_hold_s;
            end
         end
         if (!s1_ff.high_load && !s1_ff.low_load) begin
            up_v = up_hold_s;
            dn_v = dn_hold_s;
         end
      end

      up_cd_in           = up_v[ldsg_pkg::MS_W-1:0];
      dn_cd_in           = dn_v[ldsg_pkg::MS_W-1:0];
      rsp_in.active_flag = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         up_cd_ff     <= '0;
         dn_cd_ff     <= '0;
         run_ff       <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            up_cd_ff     <= up_cd_in;
            dn_cd_ff     <= dn_cd_in;
            run_ff       <= run_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action      = rsp_ff.action;
   assign rsp_ch.new_level   = rsp_ff.new_level;
   assign rsp_ch.active_flag = rsp_ff.active_flag;

   `ASSERT_SAME(a_off_clears_run, clock, reset,
      rsp_valid_ff && rsp_ff.action == ldsg_pkg::ACT_OFF,
      !rsp_ff.active_flag && rsp_ff.new_level == '0)
   `ASSERT_SAME(a_step_only_running, clock, reset,
      rsp_valid_ff && rsp_ff.action == ldsg_pkg::ACT_STEP, rsp_ff.active_flag)
   `ASSERT_SAME(a_level_only_on_step, clock, reset,
      rsp_valid_ff && rsp_ff.action != ldsg_pkg::ACT_STEP, rsp_ff.new_level == '0)
   `ASSERT_NEXT(a_state_holds_between_ticks, clock, reset,
      !reset && !s1_adv,
      $stable(up_cd_ff) && $stable(dn_cd_ff) && $stable(run_ff))
   `ASSERT_NEXT(a_tick_lands_in_result, clock, reset,
      !reset && s1_adv, rsp_valid_ff && rsp_ff.active_flag == run_ff)

endmodule

>>> test/load_based_dvfs_step_governor_test.sv
`timescale 1ns / 1ps

module load_based_dvfs_step_governor_test;

   localparam int LEVELS       = 16;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 185;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int LIMIT        = 1000000;

   typedef struct packed {
      logic [ldsg_pkg::LOAD_W-1:0]    load;
      logic [ldsg_pkg::LOAD_W-1:0]    rq;
      logic [ldsg_pkg::IDLE_W-1:0]    idle;
      logic [ldsg_pkg::ELAPSED_W-1:0] elapsed;
      logic [ldsg_pkg::LEVEL_W-1:0]   level;
   } stim_tick_type;

   typedef struct packed {
      logic                           is_reg;
      logic [ldsg_pkg::CSR_IDX_W-1:0] idx;
      logic [ldsg_pkg::CSR_DAT_W-1:0] val;
      stim_tick_type                  tick;
      logic                           typed;
      ldsg_pkg::result_type           want;
   } script_row_type;

   typedef enum int {TREND_HIGH, TREND_LOW, TREND_MID, TREND_IDLE, TREND_NOISE} trend_type;

   logic clock;
   logic reset;

   ldsg_req_if req_ch();
   ldsg_rsp_if rsp_ch();
   ldsg_csr_if csr_ch();

   load_based_dvfs_step_governor #(.LEVEL_COUNT(LEVELS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow of the register file and governor state
   logic                           cfg_use_rq;
   logic [ldsg_pkg::PCT_W-1:0]     cfg_up_thr;
   logic [ldsg_pkg::MS_W-1:0]      cfg_up_hold;
   logic [ldsg_pkg::PCT_W-1:0]     cfg_dn_thr;
   logic [ldsg_pkg::MS_W-1:0]      cfg_dn_hold;
   logic [ldsg_pkg::MS_W-1:0]      cfg_idle_off;
   logic [ldsg_pkg::LEVEL_W-1:0]   cfg_low;
   logic [ldsg_pkg::LEVEL_W-1:0]   cfg_high;
   int                             up_left;
   int                             down_left;
   logic                           unit_running;

   ldsg_pkg::result_type awaited_verdicts[$];
   int         errors = 0;
   int         cycles = 0;
   bit         calm;
   bit         hold_off_request;
   trend_type  trend;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time,
                  awaited_verdicts.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void apply_reg(logic [ldsg_pkg::CSR_IDX_W-1:0] idx,
                                     logic [ldsg_pkg::CSR_DAT_W-1:0] val);
      case (idx)
         ldsg_pkg::REG_USE_RQ:   cfg_use_rq   = val[0];
         ldsg_pkg::REG_UP_THR:   cfg_up_thr   = val[ldsg_pkg::PCT_W-1:0];
         ldsg_pkg::REG_UP_HOLD:  cfg_up_hold  = val;
         ldsg_pkg::REG_DN_THR:   cfg_dn_thr   = val[ldsg_pkg::PCT_W-1:0];
         ldsg_pkg::REG_DN_HOLD:  cfg_dn_hold  = val;
         ldsg_pkg::REG_IDLE_OFF: cfg_idle_off = val;
         ldsg_pkg::REG_LOW_LVL:  cfg_low      = val[ldsg_pkg::LEVEL_W-1:0];
         ldsg_pkg::REG_HIGH_LVL: cfg_high     = val[ldsg_pkg::LEVEL_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic ldsg_pkg::result_type govern_tick(stim_tick_type t);
      ldsg_pkg::result_type        v;
      logic [ldsg_pkg::LOAD_W-1:0] busy;
      int                          drop;
      logic                        rises;
      logic                        falls;
      v.action      = ldsg_pkg::ACT_NONE;
      v.new_level   = '0;
      v.active_flag = unit_running;
      busy = cfg_use_rq ? t.rq : t.load;
      drop = int'(t.elapsed) / 1000;
      // busy but no plain load: tick ignored
      if (busy != 0 && t.load == 0)
         return v;
      if (busy == 0 && cfg_idle_off != 0 &&
          longint'(t.idle) > longint'(cfg_idle_off) * 1000) begin
         unit_running  = 1'b0;
         v.action      = ldsg_pkg::ACT_OFF;
         v.active_flag = 1'b0;
         return v;
      end
      unit_running = 1'b1;
      rises = int'(t.load) > int'(cfg_up_thr) * 100;
      falls = int'(t.load) < int'(cfg_dn_thr) * 100;
      if (rises) begin
         up_left  -= drop;
         down_left = int'(cfg_dn_hold);
         if (up_left <= 0) begin
            if (t.level < cfg_high && int'(t.level) + 1 < LEVELS) begin
               v.action    = ldsg_pkg::ACT_STEP;
               v.new_level = t.level + 4'd1;
            end
            up_left = int'(cfg_up_hold);
         end
      end
      // a step down overrides a step up when both thresholds trip
      if (falls) begin
         up_left    = int'(cfg_up_hold);
         down_left -= drop;
         if (down_left <= 0) begin
            if (t.level > cfg_low) begin
               v.action    = ldsg_pkg::ACT_STEP;
               v.new_level = t.level - 4'd1;
            end
            down_left = int'(cfg_dn_hold);
         end
      end
      if (!rises && !falls) begin
         up_left   = int'(cfg_up_hold);
         down_left = int'(cfg_dn_hold);
      end
      v.active_flag = unit_running;
      return v;
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
   endfunction

   function automatic stim_tick_type random_tick();
      stim_tick_type t;
      int            up_edge;
      int            dn_edge;
      int            base;
      if ($urandom_range(0, 7) == 0)
         trend = trend_type'($urandom_range(0, 4));
      up_edge   = int'(cfg_up_thr) * 100;
      dn_edge   = int'(cfg_dn_thr) * 100;
      t.rq      = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 65535);
      t.idle    = $urandom();
      t.elapsed = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                               : $urandom_range(0, 40000);
      t.level   = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: t.level = cfg_low;
            1: t.level = cfg_low + 4'd1;
            2: t.level = cfg_high;
            default: t.level = cfg_high - 4'd1;
         endcase
      end
      case (trend)
         TREND_HIGH: t.load = $urandom_range(up_edge + 1, up_edge + 3000);
         TREND_LOW:  t.load = (dn_edge == 0) ? '0 : $urandom_range(0, dn_edge - 1);
         TREND_MID:  t.load = (dn_edge <= up_edge) ? $urandom_range(dn_edge, up_edge)
                                                   : $urandom_range(up_edge, dn_edge);
         TREND_IDLE: begin
            t.load = '0;
            t.rq   = '0;
            base   = int'(cfg_idle_off) * 1000;
            t.idle = (base < 1000) ? $urandom_range(0, 2000)
                                   : $urandom_range(base - 1000, base + 1000);
         end
         default: t.load = $urandom_range(0, 65535);
      endcase
      return t;
   endfunction

   function automatic script_row_type reg_row(logic [ldsg_pkg::CSR_IDX_W-1:0] idx,
                                              logic [ldsg_pkg::CSR_DAT_W-1:0] val);
      script_row_type r;
      r        = '0;
      r.is_reg = 1'b1;
      r.idx    = idx;
      r.val    = val;
      return r;
   endfunction

   function automatic script_row_type tick_row(logic [ldsg_pkg::LOAD_W-1:0] load,
                                               logic [ldsg_pkg::LOAD_W-1:0] rq,
                                               logic [ldsg_pkg::IDLE_W-1:0] idle,
                                               logic [ldsg_pkg::ELAPSED_W-1:0] el,
                                               logic [ldsg_pkg::LEVEL_W-1:0] lvl);
      script_row_type r;
      r              = '0;
      r.tick.load    = load;
      r.tick.rq      = rq;
      r.tick.idle    = idle;
      r.tick.elapsed = el;
      r.tick.level   = lvl;
      return r;
   endfunction

   function automatic script_row_type typed_row(logic [ldsg_pkg::LOAD_W-1:0] load,
                                                logic [ldsg_pkg::LOAD_W-1:0] rq,
                                                logic [ldsg_pkg::IDLE_W-1:0] idle,
                                                logic [ldsg_pkg::ELAPSED_W-1:0] el,
                                                logic [ldsg_pkg::LEVEL_W-1:0] lvl,
                                                logic [ldsg_pkg::ACTION_W-1:0] act,
                                                logic [ldsg_pkg::LEVEL_W-1:0] nl,
                                                logic af);
      script_row_type r;
      r                  = tick_row(load, rq, idle, el, lvl);
      r.typed            = 1'b1;
      r.want.action      = act;
      r.want.new_level   = nl;
      r.want.active_flag = af;
      return r;
   endfunction

   task automatic put_reg(logic [ldsg_pkg::CSR_IDX_W-1:0] idx,
                          logic [ldsg_pkg::CSR_DAT_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic send_tick(stim_tick_type t, logic typed, ldsg_pkg::result_type want);
      ldsg_pkg::result_type got;
      req_ch.valid           <= 1'b1;
      req_ch.load_hundredths <= t.load;
      req_ch.runqueue_load   <= t.rq;
      req_ch.idle_time_us    <= t.idle;
      req_ch.elapsed_us      <= t.elapsed;
      req_ch.current_level   <= t.level;
      do @(posedge clock); while (!req_ch.ready);
      got = govern_tick(t);
      awaited_verdicts.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap_len()) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (awaited_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_phase(int p);
      logic [ldsg_pkg::CSR_DAT_W-1:0] vals[8];
      case (p)
         0: begin
            // both thresholds trip on any load from 1 to 9999
            vals[ldsg_pkg::REG_USE_RQ]   = 0;
            vals[ldsg_pkg::REG_UP_THR]   = 0;
            vals[ldsg_pkg::REG_UP_HOLD]  = 0;
            vals[ldsg_pkg::REG_DN_THR]   = 100;
            vals[ldsg_pkg::REG_DN_HOLD]  = 0;
            vals[ldsg_pkg::REG_IDLE_OFF] = 0;
            vals[ldsg_pkg::REG_LOW_LVL]  = 0;
            vals[ldsg_pkg::REG_HIGH_LVL] = 15;
         end
         1: begin
            vals[ldsg_pkg::REG_USE_RQ]   = 1;
            vals[ldsg_pkg::REG_UP_THR]   = 100;
            vals[ldsg_pkg::REG_UP_HOLD]  = 16'hFFFF;
            vals[ldsg_pkg::REG_DN_THR]   = 0;
            vals[ldsg_pkg::REG_DN_HOLD]  = 16'hFFFF;
            vals[ldsg_pkg::REG_IDLE_OFF] = 16'hFFFF;
            vals[ldsg_pkg::REG_LOW_LVL]  = 15;
            vals[ldsg_pkg::REG_HIGH_LVL] = 0;
         end
         default: begin
            vals[ldsg_pkg::REG_USE_RQ]   = $urandom_range(0, 1);
            vals[ldsg_pkg::REG_UP_THR]   = $urandom_range(0, 100);
            vals[ldsg_pkg::REG_UP_HOLD]  = ($urandom_range(0, 9) == 0)
                                           ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 120);
            vals[ldsg_pkg::REG_DN_THR]   = $urandom_range(0, 100);
            vals[ldsg_pkg::REG_DN_HOLD]  = ($urandom_range(0, 9) == 0)
                                           ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 120);
            case ($urandom_range(0, 3))
               0: vals[ldsg_pkg::REG_IDLE_OFF] = 0;
               1: vals[ldsg_pkg::REG_IDLE_OFF] = 16'hFFFF;
               default: vals[ldsg_pkg::REG_IDLE_OFF] = $urandom_range(1, 60);
            endcase
            vals[ldsg_pkg::REG_LOW_LVL]  = $urandom_range(0, 7);
            vals[ldsg_pkg::REG_HIGH_LVL] = ($urandom_range(0, 4) == 0)
                                           ? $urandom_range(0, 15)
                                           : $urandom_range(8, 15);
         end
      endcase
      for (int i = 0; i < 8; i++)
         put_reg(ldsg_pkg::CSR_IDX_W'(i), vals[i]);
      csr_ch.valid <= 1'b0;
   endtask

   // result sink: random back-pressure plus one long hold-off on request
   initial begin : result_sink
      int held;
      held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (held > 0) begin
            held--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            held = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            held = gap_len() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      ldsg_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat action=%0d new_level=%0d active_flag=%0d",
                     $time, rsp_ch.action, rsp_ch.new_level, rsp_ch.active_flag);
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_ch.action !== want.action) begin
               errors++;
               $display("%0t: action expected %0d got %0d", $time, want.action,
                        rsp_ch.action);
            end
            if (rsp_ch.new_level !== want.new_level) begin
               errors++;
               $display("%0t: new_level expected %0d got %0d", $time, want.new_level,
                        rsp_ch.new_level);
            end
            if (rsp_ch.active_flag !== want.active_flag) begin
               errors++;
               $display("%0t: active_flag expected %0d got %0d", $time, want.active_flag,
                        rsp_ch.active_flag);
            end
         end
      end
   end

   initial begin : stimulus
      script_row_type script[$];
      script_row_type row;
      bit             reg_open;

      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.load_hundredths = '0;
      req_ch.runqueue_load   = '0;
      req_ch.idle_time_us    = '0;
      req_ch.elapsed_us      = '0;
      req_ch.current_level   = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = '0;
      csr_ch.data            = '0;
      calm                   = 1'b0;
      hold_off_request       = 1'b0;
      trend                  = TREND_MID;
      reg_open               = 1'b0;

      cfg_use_rq   = 1'b0;
      cfg_up_thr   = 7'd100;
      cfg_up_hold  = '0;
      cfg_dn_thr   = '0;
      cfg_dn_hold  = '0;
      cfg_idle_off = '0;
      cfg_low      = '0;
      cfg_high     = 4'd15;
      up_left      = 0;
      down_left    = 0;
      unit_running = 1'b0;

      // defaults: step up above 100 %, never down, no idle off
      script.push_back(typed_row(16'h0000, 16'h0000, 32'hFFFFFFFF, 24'h0, 4'd0,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b1));
      script.push_back(typed_row(16'hFFFF, 16'hFFFF, 32'h0, 24'hFFFFFF, 4'd0,
                                 ldsg_pkg::ACT_STEP, 4'd1, 1'b1));
      script.push_back(typed_row(16'hFFFF, 16'h0000, 32'h0, 24'h0, 4'd15,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b1));
      script.push_back(typed_row(16'd10001, 16'd1, 32'h0, 24'd999, 4'd14,
                                 ldsg_pkg::ACT_STEP, 4'd15, 1'b1));
      script.push_back(typed_row(16'd10000, 16'd0, 32'h0, 24'd1000, 4'd5,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b1));
      // idle off at the two ends of its range
      script.push_back(reg_row(ldsg_pkg::REG_IDLE_OFF, 16'd1));
      script.push_back(typed_row(16'd0, 16'd0, 32'd1001, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_OFF, 4'd0, 1'b0));
      script.push_back(typed_row(16'd0, 16'd0, 32'd1000, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b1));
      script.push_back(reg_row(ldsg_pkg::REG_IDLE_OFF, 16'hFFFF));
      script.push_back(typed_row(16'd0, 16'd0, 32'hFFFFFFFF, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_OFF, 4'd0, 1'b0));
      script.push_back(typed_row(16'd0, 16'd0, 32'd65535000, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b1));
      // run-queue as busy: skipped ticks keep the running flag
      script.push_back(reg_row(ldsg_pkg::REG_USE_RQ, 16'd1));
      script.push_back(typed_row(16'd0, 16'd1, 32'hFFFFFFFF, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b1));
      script.push_back(typed_row(16'd1, 16'd0, 32'hFFFFFFFF, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_OFF, 4'd0, 1'b0));
      script.push_back(typed_row(16'd0, 16'hFFFF, 32'h0, 24'h0, 4'd7,
                                 ldsg_pkg::ACT_NONE, 4'd0, 1'b0));
      // up threshold below down threshold, level window 3..12
      script.push_back(reg_row(ldsg_pkg::REG_UP_THR, 16'd0));
      script.push_back(reg_row(ldsg_pkg::REG_DN_THR, 16'd100));
      script.push_back(reg_row(ldsg_pkg::REG_UP_HOLD, 16'hFFFF));
      script.push_back(reg_row(ldsg_pkg::REG_DN_HOLD, 16'hFFFF));
      script.push_back(reg_row(ldsg_pkg::REG_LOW_LVL, 16'd3));
      script.push_back(reg_row(ldsg_pkg::REG_HIGH_LVL, 16'd12));
      script.push_back(tick_row(16'd5000, 16'd5000, 32'h0, 24'h0, 4'd3));
      script.push_back(tick_row(16'd5000, 16'd5000, 32'h0, 24'hFFFFFF, 4'd3));
      script.push_back(tick_row(16'd5000, 16'd5000, 32'h0, 24'hFFFFFF, 4'd11));
      script.push_back(tick_row(16'd9999, 16'd1, 32'h0, 24'hFFFFFF, 4'd12));
      script.push_back(reg_row(ldsg_pkg::REG_UP_THR, 16'd100));
      script.push_back(reg_row(ldsg_pkg::REG_DN_HOLD, 16'd0));
      script.push_back(reg_row(ldsg_pkg::REG_UP_HOLD, 16'd0));
      script.push_back(tick_row(16'd0, 16'd0, 32'h0, 24'h0, 4'd3));
      script.push_back(tick_row(16'd0, 16'd0, 32'h0, 24'h0, 4'd4));
      script.push_back(tick_row(16'd1, 16'd0, 32'h0, 24'h0, 4'd0));
      script.push_back(tick_row(16'd9999, 16'hFFFF, 32'h0, 24'h0, 4'd3));
      script.push_back(reg_row(ldsg_pkg::REG_LOW_LVL, 16'd0));
      script.push_back(reg_row(ldsg_pkg::REG_HIGH_LVL, 16'd15));
      script.push_back(reg_row(ldsg_pkg::REG_USE_RQ, 16'd0));
      script.push_back(reg_row(ldsg_pkg::REG_IDLE_OFF, 16'd0));
      script.push_back(reg_row(ldsg_pkg::REG_DN_THR, 16'd0));
      script.push_back(tick_row(16'hFFFF, 16'h0, 32'hFFFFFFFF, 24'h0, 4'd15));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.is_reg) begin
            if (!reg_open)
               settle();
            put_reg(row.idx, row.val);
            reg_open = 1'b1;
         end else begin
            if (reg_open) begin
               csr_ch.valid <= 1'b0;
               reg_open = 1'b0;
            end
            pause_sender();
            send_tick(row.tick, row.typed, row.want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         program_phase(p);
         calm = (p == 4);
         // long result stall while ticks keep coming
         if (p == 2)
            hold_off_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == PHASE_ITEMS / 2)
               settle();
            pause_sender();
            send_tick(random_tick(), 1'b0, '0);
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/ldsg_pkg.sv
rtl/ldsg_if.sv
rtl/load_based_dvfs_step_governor.sv
test/load_based_dvfs_step_governor_test.sv
